// File: rtl/core/biquad_band_pass_filter_macros.svh
// ----------------------------------------------------------------------------
// Biquad band-pass filter assertion macros
// Shared concurrent assertion wrappers for the checker.
// ----------------------------------------------------------------------------
`ifndef BIQUAD_BAND_PASS_FILTER_MACROS_SVH
`define BIQUAD_BAND_PASS_FILTER_MACROS_SVH

// checked outside reset only
`define BQ_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// checked at every edge, reset included
`define BQ_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/core/bqbpf_pkg.sv
// ----------------------------------------------------------------------------
// Biquad band-pass filter package
// Register indexes, multiplier operand codes and controller/datapath links.
// ----------------------------------------------------------------------------
package bqbpf_pkg;

  localparam int CFG_IDX_W = 3;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_B0     = 3'd0,
    REG_A1     = 3'd1,
    REG_A2     = 3'd2,
    REG_GAIN   = 3'd3,
    REG_BYPASS = 3'd4
  } reg_idx_t;

  // operand pair fed to the shared multiplier
  typedef enum logic [2:0] {
    MUL_B0_X   = 3'd0,
    MUL_B0_X2  = 3'd1,
    MUL_A1_Y1  = 3'd2,
    MUL_A2_Y2  = 3'd3,
    MUL_Y_GAIN = 3'd4
  } mul_sel_t;

  // controller to datapath
  typedef struct packed {
    logic     capture;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     acc_load;
    logic     acc_sub;
    logic     sat_y;
    logic     sat_g;
    logic     load_out;
  } bqbpf_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic bypass;
    logic out_free;
  } bqbpf_sts_t;

endpackage

// File: rtl/core/bqbpf_if.sv
// ----------------------------------------------------------------------------
// Biquad band-pass filter channel interfaces
// Valid/ready channels for samples in, results out and register writes.
// ----------------------------------------------------------------------------

// input sample channel
interface bqbpf_in_if #(parameter int SAMPLE_WIDTH = 16);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_in;
  logic                           first;

  modport source (output valid, output sample_in, output first, input ready);
  modport sink   (input valid, input sample_in, input first, output ready);
endinterface

// result channel
interface bqbpf_out_if #(parameter int SAMPLE_WIDTH = 16);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_out;
  logic                           clipped;

  modport source (output valid, output sample_out, output clipped, input ready);
  modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

// register write channel
interface bqbpf_cfg_if #(parameter int COEF_WIDTH = 16);
  logic                              valid;
  logic                              ready;
  logic [bqbpf_pkg::CFG_IDX_W-1:0]   index;
  logic [COEF_WIDTH-1:0]             data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/bqbpf_ctrl.sv
// ----------------------------------------------------------------------------
// Biquad band-pass filter controller
// Sequences the shared multiplier over the four taps, the gain and output.
// ----------------------------------------------------------------------------
module bqbpf_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  bqbpf_pkg::bqbpf_sts_t sts,
  output bqbpf_pkg::bqbpf_cmd_t cmd
);
  import bqbpf_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_MUL0 = 10'b00_0000_0010,
    S_MUL1 = 10'b00_0000_0100,
    S_MUL2 = 10'b00_0000_1000,
    S_MUL3 = 10'b00_0001_0000,
    S_ACC  = 10'b00_0010_0000,
    S_SATY = 10'b00_0100_0000,
    S_MULG = 10'b00_1000_0000,
    S_SATG = 10'b01_0000_0000,
    S_OUT  = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.mul_sel  = MUL_B0_X;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = sts.bypass ? S_OUT : S_MUL0;
        end
      end
      S_MUL0: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_B0_X;
        state_nxt   = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = MUL_B0_X2;
        cmd.acc_load = 1'b1;
        state_nxt    = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_A1_Y1;
        cmd.acc_sub = 1'b1;
        state_nxt   = S_MUL3;
      end
      S_MUL3: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_A2_Y2;
        cmd.acc_sub = 1'b1;
        state_nxt   = S_ACC;
      end
      S_ACC: begin
        cmd.acc_sub = 1'b1;
        state_nxt   = S_SATY;
      end
      S_SATY: begin
        cmd.sat_y = 1'b1;
        state_nxt = S_MULG;
      end
      S_MULG: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_Y_GAIN;
        state_nxt   = S_SATG;
      end
      S_SATG: begin
        cmd.sat_g = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/core/bqbpf_datapath.sv
// ----------------------------------------------------------------------------
// Biquad band-pass filter datapath
// Register file, history, shared multiplier, accumulator, rounding and
// saturation, and the output register.
// ----------------------------------------------------------------------------
module bqbpf_datapath #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int COEF_WIDTH   = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // register writes
  input  logic                             cfg_we,
  input  logic [bqbpf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [COEF_WIDTH-1:0]            cfg_data,
  // sample in
  input  logic signed [SAMPLE_WIDTH-1:0]   sample_in,
  input  logic                             first,
  // result out
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]   sample_out,
  output logic                             clipped,
  // control
  input  bqbpf_pkg::bqbpf_cmd_t            cmd,
  output bqbpf_pkg::bqbpf_sts_t            sts
);
  import bqbpf_pkg::*;

  localparam int SW = SAMPLE_WIDTH;
  localparam int CW = COEF_WIDTH;
  localparam int PW = SW + CW;      // product width
  localparam int AW = PW + 3;       // accumulator, headroom for four terms and rounding
  localparam int GW = PW + 1;       // gain product plus rounding
  localparam int CF = CW - 2;       // Q2.x coefficient fraction bits
  localparam int GF = CW - 4;       // Q4.x gain fraction bits

  localparam logic signed [CW-1:0] GAIN_UNITY = {3'b000, 1'b1, {(CW-4){1'b0}}};
  localparam logic signed [AW-1:0] ROUND_Y    = {{(AW-CF){1'b0}}, 1'b1, {(CF-1){1'b0}}};
  localparam logic signed [GW-1:0] ROUND_G    = {{(GW-GF){1'b0}}, 1'b1, {(GF-1){1'b0}}};
  localparam logic signed [AW-1:0] Y_MAX      = {{(AW-SW+1){1'b0}}, {(SW-1){1'b1}}};
  localparam logic signed [AW-1:0] Y_MIN      = {{(AW-SW+1){1'b1}}, {(SW-1){1'b0}}};
  localparam logic signed [GW-1:0] G_MAX      = {{(GW-SW+1){1'b0}}, {(SW-1){1'b1}}};
  localparam logic signed [GW-1:0] G_MIN      = {{(GW-SW+1){1'b1}}, {(SW-1){1'b0}}};
  localparam logic signed [SW-1:0] S_MAX      = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] S_MIN      = {1'b1, {(SW-1){1'b0}}};

  // configuration registers
  logic signed [CW-1:0] b0_r, a1_r, a2_r, gain_r;
  logic                 bypass_r;

  // sample and history
  logic signed [SW-1:0] x_r, x1_r, x2_r, y1_r, y2_r, y_r;

  // arithmetic
  logic signed [SW-1:0] op_s;
  logic signed [CW-1:0] op_c;
  logic signed [PW-1:0] prod_r;
  logic signed [AW-1:0] prod_ext;
  logic signed [AW-1:0] acc_r, acc_nxt;
  logic signed [AW-1:0] y_sum, y_shift;
  logic signed [GW-1:0] g_sum, g_shift;
  logic signed [SW-1:0] y_sat, g_sat;
  logic                 y_clip, g_clip;
  logic                 clip_r;

  // output register
  logic                 out_valid_r;
  logic signed [SW-1:0] res_r;
  logic                 res_clip_r;

  assign sts.bypass   = bypass_r;
  assign sts.out_free = !out_valid_r || out_ready;

  // register file; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_r     <= '0;
      a1_r     <= '0;
      a2_r     <= '0;
      gain_r   <= GAIN_UNITY;
      bypass_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_B0:     b0_r     <= cfg_data;
        REG_A1:     a1_r     <= cfg_data;
        REG_A2:     a2_r     <= cfg_data;
        REG_GAIN:   gain_r   <= cfg_data;
        REG_BYPASS: bypass_r <= cfg_data[0];
        default:    ;
      endcase
    end
  end

  // multiplier operand select
  always_comb begin
    unique case (cmd.mul_sel)
      MUL_B0_X:   begin op_s = x_r;  op_c = b0_r;   end
      MUL_B0_X2:  begin op_s = x2_r; op_c = b0_r;   end
      MUL_A1_Y1:  begin op_s = y1_r; op_c = a1_r;   end
      MUL_A2_Y2:  begin op_s = y2_r; op_c = a2_r;   end
      MUL_Y_GAIN: begin op_s = y_r;  op_c = gain_r; end
      default:    begin op_s = x_r;  op_c = b0_r;   end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= op_s * op_c;
    end
  end

  // accumulator: first tap loads, the rest subtract
  assign prod_ext = {{(AW-PW){prod_r[PW-1]}}, prod_r};

  always_comb begin
    acc_nxt = acc_r;
    if (cmd.acc_load) begin
      acc_nxt = prod_ext;
    end else if (cmd.acc_sub) begin
      acc_nxt = acc_r - prod_ext;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  // filter value: round half up, then clamp
  assign y_sum   = acc_r + ROUND_Y;
  assign y_shift = y_sum >>> CF;

  always_comb begin
    y_clip = 1'b0;
    y_sat  = y_shift[SW-1:0];
    if (y_shift > Y_MAX) begin
      y_clip = 1'b1;
      y_sat  = S_MAX;
    end else if (y_shift < Y_MIN) begin
      y_clip = 1'b1;
      y_sat  = S_MIN;
    end
  end

  // gain value: round half up, then clamp
  assign g_sum   = {prod_r[PW-1], prod_r} + ROUND_G;
  assign g_shift = g_sum >>> GF;

  always_comb begin
    g_clip = 1'b0;
    g_sat  = g_shift[SW-1:0];
    if (g_shift > G_MAX) begin
      g_clip = 1'b1;
      g_sat  = S_MAX;
    end else if (g_shift < G_MIN) begin
      g_clip = 1'b1;
      g_sat  = S_MIN;
    end
  end

  // sample capture and history; a buffer start clears history
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x1_r <= '0;
      x2_r <= '0;
      y1_r <= '0;
      y2_r <= '0;
    end else if (cmd.capture && first) begin
      x1_r <= '0;
      x2_r <= '0;
      y1_r <= '0;
      y2_r <= '0;
    end else if (cmd.sat_y) begin
      x2_r <= x1_r;
      x1_r <= x_r;
      y2_r <= y1_r;
      y1_r <= y_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      x_r <= sample_in;
    end
    if (cmd.sat_y) begin
      y_r    <= y_sat;
      clip_r <= y_clip;
    end
  end

  // pending result; bypass passes the sample with no clip
  always_ff @(posedge clk) begin
    if (cmd.capture && bypass_r) begin
      res_r      <= sample_in;
      res_clip_r <= 1'b0;
    end else if (cmd.sat_g) begin
      res_r      <= g_sat;
      res_clip_r <= clip_r || g_clip;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      sample_out <= res_r;
      clipped    <= res_clip_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: rtl/core/biquad_band_pass_filter.sv
// Flow: an accepted sample passes the four tap products on the single shared multiplier,
// the accumulate and filter clamp, the gain product and the gain clamp, then loads
// the output register once the previous result there is taken or gone; bypass loads
// it directly. A new sample is taken only after that load.
// Reset: synchronous active-low rst_n clears history, coefficients (gain to unity)
// and the controller; the output register comes up empty.
// ----------------------------------------------------------------------------
// Biquad band-pass filter top level
// Direct-form-I band-pass biquad with output gain and clip flag.
// ----------------------------------------------------------------------------
module biquad_band_pass_filter #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int COEF_WIDTH   = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  bqbpf_in_if.sink   in_ch,
  bqbpf_out_if.source out_ch,
  bqbpf_cfg_if.sink  cfg_ch
);
  import bqbpf_pkg::*;

  bqbpf_cmd_t cmd;
  bqbpf_sts_t sts;

  // register writes are always taken
  assign cfg_ch.ready = 1'b1;

  bqbpf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bqbpf_datapath #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COEF_WIDTH   (COEF_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_ch.valid),
    .cfg_index  (cfg_ch.index),
    .cfg_data   (cfg_ch.data),
    .sample_in  (in_ch.sample_in),
    .first      (in_ch.first),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .sample_out (out_ch.sample_out),
    .clipped    (out_ch.clipped),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

// File: rtl/core/bqbpf_checker.sv
// ----------------------------------------------------------------------------
// Biquad band-pass filter checker
// Port-level assertions on the filter, bound to the top level.
// ----------------------------------------------------------------------------
`include "biquad_band_pass_filter_macros.svh"

module bqbpf_checker #(
  parameter int SAMPLE_WIDTH = 16
) (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [SAMPLE_WIDTH-1:0] sample_out,
  input logic                    clipped
);

  // a waiting result stays offered
  `BQ_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "result dropped while stalled")

  // a waiting result keeps its value
  `BQ_ASSERT(a_out_stable, clk, rst_n, out_valid && !out_ready |=> $stable(sample_out) && $stable(clipped), "stalled result changed")

  // one item at a time: busy straight after an accept
  `BQ_ASSERT(a_busy_after_accept, clk, rst_n, in_valid && in_ready |=> !in_ready, "accepted a second item while busy")

  // reset empties the output register
  `BQ_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "result offered after reset")

endmodule

bind biquad_band_pass_filter bqbpf_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .sample_out (out_ch.sample_out),
  .clipped    (out_ch.clipped)
);

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Biquad band-pass filter testbench
// Drives samples, register writes and receiver back-pressure through the
// valid/ready channels, and checks every result against a bit-exact
// fixed-point prediction of the biquad, the output gain and the clip flag.
// ----------------------------------------------------------------------------
module tb;
  import bqbpf_pkg::*;

  localparam int SW = 16;
  localparam int CW = 16;
  localparam longint SMP_MAX = (longint'(1) << (SW - 1)) - 1;
  localparam longint SMP_MIN = -SMP_MAX - 1;
  localparam int WATCHDOG_LIMIT = 2000;
  // allow a generous margin at the end
  localparam int DRAIN_CYCLES = 32;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS = 85;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = CFG_IDX_W'(REG_BYPASS + 1);
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = '1;

  typedef struct packed {
    logic signed [SW-1:0] smp;
    logic                 clipped;
  } filt_out_t;

  typedef enum int { RX_ALWAYS, RX_COIN, RX_PATTERN } rx_mode_t;
  typedef enum int { COEF_BANDPASS, COEF_WILD, COEF_EXTREME } coef_kind_t;

  logic clk = 1'b0;
  logic rst_n;

  // clock: 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bqbpf_in_if  #(.SAMPLE_WIDTH(SW)) in_if ();
  bqbpf_out_if #(.SAMPLE_WIDTH(SW)) out_if ();
  bqbpf_cfg_if #(.COEF_WIDTH(CW))   cfg_if ();

  biquad_band_pass_filter #(.SAMPLE_WIDTH(SW), .COEF_WIDTH(CW)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // predictor copy of registers and filter history
  logic signed [CW-1:0] p_b0 = '0;
  logic signed [CW-1:0] p_a1 = '0;
  logic signed [CW-1:0] p_a2 = '0;
  logic signed [CW-1:0] p_gain = CW'(1 << (CW - 4));
  logic                 p_bypass = 1'b0;
  logic signed [SW-1:0] p_x1 = '0;
  logic signed [SW-1:0] p_x2 = '0;
  logic signed [SW-1:0] p_y1 = '0;
  logic signed [SW-1:0] p_y2 = '0;

  filt_out_t pending_outputs[$];
  int        fail_count = 0;
  int        burst_left = 0;
  int        stall_cycles = 0;
  rx_mode_t  rx_mode = RX_ALWAYS;
  logic [7:0] rx_pattern = 8'hFF;
  logic [2:0] rx_phase = '0;

  function automatic longint clamp_sample(longint v, inout bit clip);
    if (v > SMP_MAX) begin
      clip = 1'b1;
      return SMP_MAX;
    end
    if (v < SMP_MIN) begin
      clip = 1'b1;
      return SMP_MIN;
    end
    return v;
  endfunction

  // next filter output; advances the predicted history
  function automatic filt_out_t filter_next(logic signed [SW-1:0] x, logic first);
    filt_out_t r;
    longint    acc;
    longint    yv;
    longint    gv;
    bit        clip;
    clip = 1'b0;
    if (first) begin
      p_x1 = '0;
      p_x2 = '0;
      p_y1 = '0;
      p_y2 = '0;
    end
    if (p_bypass) begin
      r.smp = x;
      r.clipped = 1'b0;
      return r;
    end
    // b1 is zero and b2 is -b0; round half up, then floor
    acc = longint'(p_b0) * longint'(x) - longint'(p_b0) * longint'(p_x2)
        - longint'(p_a1) * longint'(p_y1) - longint'(p_a2) * longint'(p_y2)
        + (longint'(1) << (CW - 3));
    yv = clamp_sample(acc >>> (CW - 2), clip);
    p_x2 = p_x1;
    p_x1 = x;
    p_y2 = p_y1;
    p_y1 = SW'(yv);
    gv = yv * longint'(p_gain) + (longint'(1) << (CW - 5));
    gv = clamp_sample(gv >>> (CW - 4), clip);
    r.smp = SW'(gv);
    r.clipped = clip;
    return r;
  endfunction

  // result check first, then prediction of any item taken at this edge
  always @(posedge clk) begin : check_outputs
    filt_out_t want;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        if (pending_outputs.size() == 0) begin
          $error("sample_out: expected none, got %0d", out_if.sample_out);
          fail_count++;
        end else begin
          want = pending_outputs.pop_front();
          if (out_if.sample_out !== want.smp) begin
            $error("sample_out: expected %0d, got %0d", want.smp, out_if.sample_out);
            fail_count++;
          end
          if (out_if.clipped !== want.clipped) begin
            $error("clipped: expected %0b, got %0b", want.clipped, out_if.clipped);
            fail_count++;
          end
        end
      end
      if (in_if.valid && in_if.ready) begin
        want = filter_next(in_if.sample_in, in_if.first);
        pending_outputs = {pending_outputs, want};
      end
    end
  end

  // watchdog on cycles with no handshake on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)
        || (cfg_if.valid && cfg_if.ready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL biquad_band_pass_filter");
      $finish;
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    case (rx_mode)
      RX_ALWAYS: out_if.ready <= 1'b1;
      RX_COIN:   out_if.ready <= 1'($urandom_range(0, 1));
      default:   out_if.ready <= rx_pattern[rx_phase];
    endcase
    rx_phase <= rx_phase + 1'b1;
  end

  // one item on the input channel; valid stays high within a burst
  task automatic send_sample(input logic signed [SW-1:0] x, input logic first);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_if.valid     <= 1'b1;
    in_if.sample_in <= x;
    in_if.first     <= first;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    @(negedge clk);
    burst_left--;
  endtask

  // stop sending, wait for every result, then pick a new stall pattern
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    burst_left = 0;
    while (pending_outputs.size() != 0) @(negedge clk);
    rx_mode    = rx_mode_t'($urandom_range(0, 2));
    rx_pattern = 8'($urandom) | 8'h01;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CW-1:0] value);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    case (idx)
      REG_B0:     p_b0 = value;
      REG_A1:     p_a1 = value;
      REG_A2:     p_a2 = value;
      REG_GAIN:   p_gain = value;
      REG_BYPASS: p_bypass = value[0];
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // all five registers; bypass carries random upper bits
  task automatic program_filter(input logic signed [CW-1:0] b0, input logic signed [CW-1:0] a1,
                                input logic signed [CW-1:0] a2, input logic signed [CW-1:0] gain,
                                input logic byp);
    write_reg(REG_B0, b0);
    write_reg(REG_A1, a1);
    write_reg(REG_A2, a2);
    write_reg(REG_GAIN, gain);
    write_reg(REG_BYPASS, {(CW - 1)'($urandom), byp});
    end_writes();
  endtask

  function automatic logic signed [SW-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return SW'(SMP_MAX);
      1:       return SW'(SMP_MIN);
      2:       return SW'($urandom_range(0, 2) - 1);
      3, 4:    return SW'(int'($urandom_range(0, 2047)) - 1024);
      default: return SW'($urandom);
    endcase
  endfunction

  function automatic logic signed [CW-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0:       return CW'(1 << (CW - 4));
      1:       return CW'(SMP_MAX);
      2:       return CW'(SMP_MIN);
      3:       return CW'(int'($urandom_range(0, 8191)) - 4096);
      default: return CW'($urandom);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // register reset values: b0 zero, unity gain
  task automatic test_reset_values();
    wait_drained();
    send_sample(16'sd32767, 1'b1);
    send_sample(-16'sd32768, 1'b0);
    send_sample(16'sd1234, 1'b0);
  endtask

  // y = x - x2 with sample extremes, including filter saturation
  task automatic test_difference_extremes();
    wait_drained();
    program_filter(16'sd16384, 16'sd0, 16'sd0, 16'sd4096, 1'b0);
    send_sample(16'sd32767, 1'b1);
    send_sample(-16'sd32768, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd32767, 1'b0);
    send_sample(-16'sd1, 1'b0);
  endtask

  // exact half-LSB ties round toward plus infinity, in the filter and the gain
  task automatic test_rounding_ties();
    wait_drained();
    program_filter(16'sd1, 16'sd0, 16'sd0, 16'sd4096, 1'b0);
    send_sample(16'sd8192, 1'b1);
    send_sample(-16'sd8192, 1'b1);
    send_sample(16'sd24576, 1'b1);
    send_sample(-16'sd24576, 1'b1);
    wait_drained();
    program_filter(16'sd16384, 16'sd0, 16'sd0, 16'sd2048, 1'b0);
    send_sample(16'sd1, 1'b1);
    send_sample(-16'sd1, 1'b1);
  endtask

  // coefficient and gain extremes: both saturation stages
  task automatic test_saturation();
    wait_drained();
    program_filter(-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767, 1'b0);
    send_sample(-16'sd32768, 1'b1);
    send_sample(16'sd32767, 1'b0);
    send_sample(-16'sd32768, 1'b0);
    wait_drained();
    program_filter(-16'sd32768, 16'sd32767, -16'sd32768, -16'sd32768, 1'b0);
    send_sample(16'sd12345, 1'b0);
  endtask

  // bypass passes samples, still clears history on a buffer start
  task automatic test_bypass();
    wait_drained();
    program_filter(16'sd16384, 16'sd0, 16'sd0, 16'sd4096, 1'b1);
    send_sample(16'sd32767, 1'b0);
    send_sample(-16'sd32768, 1'b1);
    send_sample(16'sd100, 1'b0);
    wait_drained();
    program_filter(16'sd16384, 16'sd0, 16'sd0, 16'sd4096, 1'b0);
    send_sample(16'sd5, 1'b0);
    send_sample(16'sd7, 1'b0);
  endtask

  // writes to unused indexes change nothing
  task automatic test_spare_indexes();
    wait_drained();
    for (int i = IDX_SPARE_LO; i <= IDX_SPARE_HI; i++)
      write_reg(CFG_IDX_W'(i), CW'($urandom));
    end_writes();
    send_sample(16'sd20000, 1'b0);
    send_sample(-16'sd20000, 1'b0);
  endtask

  // random settings per phase, buffers of random length and content
  task automatic test_random_traffic();
    int                   sent;
    int                   len;
    int                   lim;
    coef_kind_t           kind;
    logic signed [CW-1:0] b0;
    logic signed [CW-1:0] a1;
    logic signed [CW-1:0] a2;
    logic                 byp;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_drained();
      kind = (ph == 1) ? COEF_EXTREME : coef_kind_t'($urandom_range(0, 2));
      case (kind)
        COEF_BANDPASS: begin
          b0  = CW'($urandom_range(200, 6000));
          a2  = CW'($urandom_range(6000, 16000));
          lim = 16384 + int'(a2) - 256;
          a1  = CW'(int'($urandom_range(0, 2 * lim)) - lim);
        end
        COEF_EXTREME: begin
          b0 = $urandom_range(0, 1) ? CW'(SMP_MAX) : CW'(SMP_MIN);
          a1 = $urandom_range(0, 1) ? CW'(SMP_MAX) : CW'(SMP_MIN);
          a2 = $urandom_range(0, 1) ? CW'(SMP_MAX) : CW'(SMP_MIN);
        end
        default: begin
          b0 = CW'($urandom);
          a1 = CW'($urandom);
          a2 = CW'($urandom);
        end
      endcase
      byp = (ph == 2) || ($urandom_range(0, 7) == 0);
      program_filter(b0, a1, a2, pick_gain(), byp);
      if ($urandom_range(0, 2) == 0) begin
        write_reg(CFG_IDX_W'($urandom_range(IDX_SPARE_LO, IDX_SPARE_HI)), CW'($urandom));
        end_writes();
      end
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        len = $urandom_range(1, 40);
        for (int i = 0; i < len && sent < PHASE_ITEMS; i++) begin
          // mostly well-formed buffers, with stray starts and missing ones
          send_sample(pick_sample(), (i == 0) ? ($urandom_range(0, 9) != 0)
                                              : ($urandom_range(0, 31) == 0));
          sent++;
        end
      end
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    in_if.valid      = 1'b0;
    in_if.sample_in  = '0;
    in_if.first      = 1'b0;
    out_if.ready     = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = '0;
    cfg_if.data      = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_values();
    test_difference_extremes();
    test_rounding_ties();
    test_saturation();
    test_bypass();
    test_spare_indexes();
    test_random_traffic();

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0)
      $display("PASS biquad_band_pass_filter");
    else
      $display("FAIL biquad_band_pass_filter");
    $finish;
  end

endmodule
